// ===== sv/egcd_pkg.sv =====
// ============================================================================
// egcd_pkg
// Shared widths, microcode encoding and control types of the GCD core.
// ============================================================================
package egcd_pkg;

    // Operand width used inside the core; ports stay 64 bits wide.
    localparam int DATA_WIDTH = 64;
    localparam int PORT_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int PC_W       = 3;

    typedef logic [DATA_WIDTH-1:0]        t_word;
    typedef logic signed [DATA_WIDTH-1:0] t_sword;
    typedef logic [PC_W-1:0]              t_pc;

    // Datapath operation selected by a microcode step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETUP,
        OP_DIVSTEP,
        OP_SWAP,
        OP_EMIT
    } t_op;

    // Jump condition: when it holds the step jumps to its target,
    // otherwise the step counter advances by one.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_B_ZERO,
        COND_CNT_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Step addresses of the program.
    localparam t_pc STEP_IDLE  = 3'd0;
    localparam t_pc STEP_TEST  = 3'd1;
    localparam t_pc STEP_SETUP = 3'd2;
    localparam t_pc STEP_DIV   = 3'd3;
    localparam t_pc STEP_SWAP  = 3'd4;
    localparam t_pc STEP_EMIT  = 3'd5;
    localparam t_pc STEP_RET   = 3'd6;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic b_zero;
        logic cnt_last;
        logic out_busy;
    } t_status;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic in_take;
        logic emit;
    } t_ctrl;

    // The microprogram.
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        case (pc)
            STEP_IDLE:  w = '{op: OP_LOAD,    cond: COND_NO_INPUT, target: STEP_IDLE};
            STEP_TEST:  w = '{op: OP_NOP,     cond: COND_B_ZERO,   target: STEP_EMIT};
            STEP_SETUP: w = '{op: OP_SETUP,   cond: COND_NEVER,    target: STEP_IDLE};
            STEP_DIV:   w = '{op: OP_DIVSTEP, cond: COND_CNT_MORE, target: STEP_DIV};
            STEP_SWAP:  w = '{op: OP_SWAP,    cond: COND_ALWAYS,   target: STEP_TEST};
            STEP_EMIT:  w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: STEP_EMIT};
            STEP_RET:   w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_IDLE};
            default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/euclid_gcd_int64_core.sv =====
// ============================================================================
// euclid_gcd_int64_core
// Greatest common divisor of two signed integers by Euclid's remainder loop.
// ============================================================================
// Usage:
//   The input channel (i_in_valid / o_in_stall) takes one beat holding the
//   two operands; only their low DATA_WIDTH bits count, as two's complement.
//   The output channel (o_out_valid / i_out_stall) delivers one beat with the
//   divisor, sign-extended to 64 bits. Its sign follows the truncating
//   remainder loop, so gcd(4,-6) = -2; a zero second operand returns the
//   first one unchanged.
// Timing:
//   A microcoded sequencer steps a small program over a plain datapath. Each
//   Euclid iteration runs the test, setup, divide and swap steps; the divide
//   step repeats for every quotient bit of the bit-serial restoring remainder
//   (one quotient bit per cycle). The divisor is loaded in the emit step once
//   the test step finds the second operand zero. One item is worked on at a
//   time. After the result is loaded the sequencer passes the return step to
//   the idle step, where o_in_stall drops and the next beat can be taken.
// Reset and stall:
//   Synchronous active-low reset returns the step counter to the idle step
//   and empties the result register. The result register holds a finished
//   beat while the receiver stalls; a new item may already be accepted, but
//   its own result waits in the emit step until the register is free.
// ============================================================================
module euclid_gcd_int64_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [63:0] i_first_value,
    input  logic signed [63:0] i_second_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [63:0] o_divisor
);

    // Control and status between the sequencer and the datapath.
    egcd_pkg::t_ctrl   w_ctrl;
    egcd_pkg::t_status w_status;

    // The sequencer owns the step counter and the microcode table.
    egcd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the operand pair, the remainder unit and the result.
    egcd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_divisor      (o_divisor)
    );

endmodule

// ===== sv/egcd_sequencer.sv =====
// ============================================================================
// egcd_sequencer
// Step counter and microcode table; evaluates the jump condition of each step.
// ============================================================================
module egcd_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  egcd_pkg::t_status i_status,
    output egcd_pkg::t_ctrl   o_ctrl,
    output logic              o_in_stall
);

    egcd_pkg::t_pc    r_pc;
    egcd_pkg::t_pc    n_pc;
    egcd_pkg::t_uword w_uword;
    logic             w_jump;

    assign w_uword = egcd_pkg::ucode_rom(r_pc);

    always_comb begin
        unique case (w_uword.cond)
            egcd_pkg::COND_NEVER:    w_jump = 1'b0;
            egcd_pkg::COND_ALWAYS:   w_jump = 1'b1;
            egcd_pkg::COND_NO_INPUT: w_jump = !i_in_valid;
            egcd_pkg::COND_B_ZERO:   w_jump = i_status.b_zero;
            egcd_pkg::COND_CNT_MORE: w_jump = !i_status.cnt_last;
            egcd_pkg::COND_OUT_BUSY: w_jump = i_status.out_busy;
            default:                 w_jump = 1'b1;
        endcase
    end

    // Next step.
    always_comb begin
        n_pc = w_jump ? w_uword.target : egcd_pkg::t_pc'(r_pc + 1'b1);
    end

    // Control outputs of the current step.
    always_comb begin
        o_ctrl.op      = w_uword.op;
        o_ctrl.in_take = (w_uword.op == egcd_pkg::OP_LOAD) && i_in_valid;
        o_ctrl.emit    = (w_uword.op == egcd_pkg::OP_EMIT) && !i_status.out_busy;
        o_in_stall     = (w_uword.op != egcd_pkg::OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= egcd_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== sv/egcd_datapath.sv =====
// ============================================================================
// egcd_datapath
// Operand registers, bit-serial restoring remainder unit and result register.
// ============================================================================
module egcd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  egcd_pkg::t_ctrl                 i_ctrl,
    input  logic signed [egcd_pkg::PORT_WIDTH-1:0] i_first_value,
    input  logic signed [egcd_pkg::PORT_WIDTH-1:0] i_second_value,
    input  logic                            i_out_stall,
    output egcd_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic signed [egcd_pkg::PORT_WIDTH-1:0] o_divisor
);

    localparam int W = egcd_pkg::DATA_WIDTH;

    egcd_pkg::t_sword r_a;
    egcd_pkg::t_sword r_b;
    egcd_pkg::t_word  r_dvd;
    egcd_pkg::t_word  r_dvs;
    egcd_pkg::t_word  r_rem;
    logic [egcd_pkg::CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic signed [egcd_pkg::PORT_WIDTH-1:0] r_out;
    logic             r_out_valid;

    egcd_pkg::t_word  w_mag_a;
    egcd_pkg::t_word  w_mag_b;
    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    egcd_pkg::t_word  w_rem_next;

    // Magnitudes; the most negative value maps onto itself as an unsigned word.
    assign w_mag_a = r_a[W-1] ? egcd_pkg::t_word'(-r_a) : egcd_pkg::t_word'(r_a);
    assign w_mag_b = r_b[W-1] ? egcd_pkg::t_word'(-r_b) : egcd_pkg::t_word'(r_b);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign w_trial    = {r_rem, r_dvd[W-1]};
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign w_rem_next = w_diff[W] ? w_trial[W-1:0] : w_diff[W-1:0];

    always_comb begin
        o_status.b_zero   = (r_b == '0);
        o_status.cnt_last = (r_cnt == egcd_pkg::CNT_W'(W - 1));
        o_status.out_busy = r_out_valid && i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_take) begin
            r_a <= i_first_value[W-1:0];
            r_b <= i_second_value[W-1:0];
        end
        unique case (i_ctrl.op)
            egcd_pkg::OP_SETUP: begin
                r_dvd <= w_mag_a;
                r_dvs <= w_mag_b;
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= r_a[W-1];
            end
            egcd_pkg::OP_DIVSTEP: begin
                r_dvd <= {r_dvd[W-2:0], 1'b0};
                r_rem <= w_rem_next;
                r_cnt <= r_cnt + 1'b1;
            end
            egcd_pkg::OP_SWAP: begin
                r_a <= r_b;
                r_b <= r_neg ? egcd_pkg::t_sword'(-r_rem) : egcd_pkg::t_sword'(r_rem);
            end
            default: begin
            end
        endcase
        if (i_ctrl.emit) begin
            r_out <= egcd_pkg::PORT_WIDTH'(r_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_divisor   = r_out;

endmodule

// ===== sv/egcd_checker.sv =====
// ============================================================================
// egcd_checker
// Port-level checks of the GCD core, bound to the top level.
// ============================================================================
module egcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_divisor
);

    // A stalled result beat stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_divisor))
        else $error("stalled result beat changed");

    // After accepting an item the core stalls its input in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset leaves the core ready for an item.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("core not ready after reset");

endmodule

bind euclid_gcd_int64_core egcd_checker u_egcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_divisor   (o_divisor)
);
